@@ design/gap_buffer_text_editor_macros.svh @@
// assertion macros for the gap buffer text editor
// expects clk and arst_n in the scope of each use
`ifndef GAP_BUFFER_TEXT_EDITOR_MACROS_SVH
`define GAP_BUFFER_TEXT_EDITOR_MACROS_SVH

// plain property, checked out of reset
`define GBTE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// overlapping implication, checked out of reset
`define GBTE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define GBTE_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/gbte_pkg.sv @@
// shared constants, types and helpers for the gap buffer text editor
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package gbte_pkg;

	localparam int CAPACITY = 1024;
	localparam int WINDOW   = 10;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int LEN_W    = $clog2(CAPACITY + 1);
	localparam int CNT_W    = 11;
	localparam int CHAR_W   = 8;
	localparam int WIN_W    = $clog2(WINDOW + 1);
	localparam int MAX_W    = (LEN_W > CNT_W) ? LEN_W : CNT_W;

	typedef enum logic [1:0] {
		ACT_APPEND = 2'd0,
		ACT_DELETE = 2'd1,
		ACT_LEFT   = 2'd2,
		ACT_RIGHT  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_COPY,
		ST_WIN
	} state_t;

	// lesser of the request and what is available on that side
	function automatic logic [MAX_W-1:0] clamp_req(input logic [CNT_W-1:0] req,
			input logic [LEN_W-1:0] avail);
		logic [MAX_W-1:0] r;
		logic [MAX_W-1:0] a;
		r = MAX_W'(req);
		a = MAX_W'(avail);
		return (r < a) ? r : a;
	endfunction

endpackage
`default_nettype wire

@@ design/gbte_ram.sv @@
// generic single-port-write, single-port-read ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module gbte_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

@@ design/gap_buffer_text_editor.sv @@
// a move copies its characters across the gap one by one and then reads the window;
// an append or a delete goes straight to the window read
// throughput: one item at a time, the copy loop moves one character per cycle through
// the text ram and the window takes one ram read per character; busy drops with the
// strobe, so the next item can be taken in the strobe cycle; results cannot be held off
// reset clears both lengths and all control; the text ram is not cleared
`timescale 1ns / 1ps
`default_nettype none
`include "gap_buffer_text_editor_macros.svh"
module gap_buffer_text_editor
	import gbte_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [1:0]        action,
	input  wire logic [CHAR_W-1:0] char_in,
	input  wire logic [CNT_W-1:0]  count,
	output logic                   valid,
	output logic [CNT_W-1:0]       count_done,
	output logic [WIN_W-1:0]       window_length,
	output logic [CHAR_W-1:0]      window_0,
	output logic [CHAR_W-1:0]      window_1,
	output logic [CHAR_W-1:0]      window_2,
	output logic [CHAR_W-1:0]      window_3,
	output logic [CHAR_W-1:0]      window_4,
	output logic [CHAR_W-1:0]      window_5,
	output logic [CHAR_W-1:0]      window_6,
	output logic [CHAR_W-1:0]      window_7,
	output logic [CHAR_W-1:0]      window_8,
	output logic [CHAR_W-1:0]      window_9
);

	state_t            state_q, state_d;
	action_t           act_q;
	action_t           act_in;
	logic [LEN_W-1:0]  left_q, right_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  done_q;
	logic              valid_q;
	logic [WIN_W-1:0]  win_idx_q;
	logic [WIN_W-1:0]  win_len_q;
	logic [CHAR_W-1:0] win_q [WINDOW];

	logic              wr_pend_s1;
	logic [ADDR_W-1:0] wr_addr_s1;
	logic              cap_pend_s1;
	logic [WIN_W-1:0]  cap_slot_s1;

	logic              we;
	logic [ADDR_W-1:0] waddr, raddr;
	logic [CHAR_W-1:0] wdata, rd_data;

	logic              full;
	logic [MAX_W-1:0]  clamp_left, clamp_right;
	logic [LEN_W-1:0]  src_left, src_right, dst_left;
	logic [WIN_W-1:0]  wlen;
	logic [LEN_W-1:0]  win_start, win_addr;
	logic              win_finish;

	assign act_in      = action_t'(action);
	assign full        = (left_q + right_q) == LEN_W'(CAPACITY);
	assign clamp_left  = clamp_req(count, left_q);
	assign clamp_right = clamp_req(count, right_q);
	assign src_left    = left_q - LEN_W'(1);
	assign src_right   = LEN_W'(CAPACITY) - right_q;
	assign dst_left    = LEN_W'(CAPACITY) - right_q - LEN_W'(1);
	assign wlen        = (left_q < LEN_W'(WINDOW)) ? WIN_W'(left_q) : WIN_W'(WINDOW);
	assign win_start   = left_q - LEN_W'(wlen);
	assign win_addr    = win_start + LEN_W'(win_idx_q);
	assign win_finish  = (win_idx_q == wlen) && !cap_pend_s1;

	gbte_ram #(
		.WIDTH(CHAR_W),
		.DEPTH(CAPACITY)
	) u_text (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and ram control
	always_comb begin
		state_d = state_q;
		we      = wr_pend_s1;
		waddr   = wr_pend_s1 ? wr_addr_s1 : left_q[ADDR_W-1:0];
		wdata   = wr_pend_s1 ? rd_data : char_in;
		raddr   = (act_q == ACT_LEFT) ? src_left[ADDR_W-1:0] : src_right[ADDR_W-1:0];
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (act_in == ACT_APPEND && !full) begin
						we = 1'b1;
					end
					state_d = (act_in inside {ACT_LEFT, ACT_RIGHT}) ? ST_COPY : ST_WIN;
				end
			end
			ST_COPY: begin
				if (rem_q == '0) begin
					state_d = ST_WIN;
				end
			end
			ST_WIN: begin
				raddr = win_addr[ADDR_W-1:0];
				if (win_finish) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q      <= '0;
			right_q     <= '0;
			rem_q       <= '0;
			valid_q     <= 1'b0;
			win_idx_q   <= '0;
			wr_pend_s1  <= 1'b0;
			cap_pend_s1 <= 1'b0;
		end else begin
			valid_q     <= 1'b0;
			wr_pend_s1  <= 1'b0;
			cap_pend_s1 <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						win_idx_q <= '0;
						case (act_in)
							ACT_APPEND: begin
								if (!full) begin
									left_q <= left_q + LEN_W'(1);
								end
							end
							ACT_DELETE: left_q <= left_q - LEN_W'(clamp_left);
							ACT_LEFT:   rem_q  <= CNT_W'(clamp_left);
							ACT_RIGHT:  rem_q  <= CNT_W'(clamp_right);
							default: ;
						endcase
					end
				end
				ST_COPY: begin
					if (rem_q != '0) begin
						wr_pend_s1 <= 1'b1;
						rem_q      <= rem_q - CNT_W'(1);
						if (act_q == ACT_LEFT) begin
							left_q  <= left_q - LEN_W'(1);
							right_q <= right_q + LEN_W'(1);
						end else begin
							left_q  <= left_q + LEN_W'(1);
							right_q <= right_q - LEN_W'(1);
						end
					end
				end
				ST_WIN: begin
					if (win_idx_q != wlen) begin
						cap_pend_s1 <= 1'b1;
						win_idx_q   <= win_idx_q + WIN_W'(1);
					end else if (!cap_pend_s1) begin
						valid_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cap_pend_s1) begin
			win_q[cap_slot_s1] <= rd_data;
		end
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					act_q <= act_in;
					for (int i = 0; i < WINDOW; i++) begin
						win_q[i] <= '0;
					end
					case (act_in)
						ACT_APPEND: done_q <= full ? '0 : CNT_W'(1);
						ACT_DELETE: done_q <= CNT_W'(clamp_left);
						ACT_LEFT:   done_q <= CNT_W'(clamp_left);
						ACT_RIGHT:  done_q <= CNT_W'(clamp_right);
						default:    done_q <= '0;
					endcase
				end
			end
			ST_COPY: begin
				wr_addr_s1 <= (act_q == ACT_LEFT) ? dst_left[ADDR_W-1:0] : left_q[ADDR_W-1:0];
			end
			ST_WIN: begin
				cap_slot_s1 <= win_idx_q;
				if (win_finish) begin
					win_len_q <= wlen;
				end
			end
			default: ;
		endcase
	end

	assign busy          = (state_q != ST_IDLE);
	assign valid         = valid_q;
	assign count_done    = done_q;
	assign window_length = win_len_q;
	assign window_0      = win_q[0];
	assign window_1      = win_q[1];
	assign window_2      = win_q[2];
	assign window_3      = win_q[3];
	assign window_4      = win_q[4];
	assign window_5      = win_q[5];
	assign window_6      = win_q[6];
	assign window_7      = win_q[7];
	assign window_8      = win_q[8];
	assign window_9      = win_q[9];

	`GBTE_ASSERT(a_len_bound, ({1'b0, left_q} + {1'b0, right_q}) <= (LEN_W + 1)'(CAPACITY), "text exceeds capacity")
	`GBTE_ASSERT_NXT(a_strobe_one, valid_q, !valid_q, "result strobe longer than one cycle")
	`GBTE_ASSERT_IMP(a_copy_wr, wr_pend_s1, state_q == ST_COPY, "copy write outside copy phase")
	`GBTE_ASSERT_NXT(a_take_busy, start && !busy, busy, "item taken but block not busy")
	`GBTE_ASSERT_IMP(a_win_len, valid_q, win_len_q <= WIN_W'(WINDOW), "window length out of range")

endmodule
`default_nettype wire

@@ bench/gap_buffer_text_editor_checker.sv @@
`timescale 1ns / 1ps
// checker for the gap buffer text editor: keeps its own text and cursor,
// predicts every accepted item and compares each result strobe; uses gbte_pkg
module gap_buffer_text_editor_checker
	import gbte_pkg::*;
(
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	input  wire logic                            busy,
	input  wire logic [1:0]                      action,
	input  wire logic [CHAR_W-1:0]               char_in,
	input  wire logic [CNT_W-1:0]                count,
	input  wire logic                            valid,
	input  wire logic [CNT_W-1:0]                count_done,
	input  wire logic [WIN_W-1:0]                window_length,
	input  wire logic [WINDOW-1:0][CHAR_W-1:0]   window,
	output int                                   fail_count,
	output int                                   pending_count
);

	typedef struct packed {
		logic [CNT_W-1:0]              done;
		logic [WIN_W-1:0]              wlen;
		logic [WINDOW-1:0][CHAR_W-1:0] win;
	} edit_result_t;

	logic [CHAR_W-1:0] text_mem [CAPACITY];
	int unsigned       left_len;
	int unsigned       right_len;
	edit_result_t      result_q[$];
	int                fail_total;

	function automatic edit_result_t apply_edit(action_t act, logic [CHAR_W-1:0] ch,
			logic [CNT_W-1:0] req);
		edit_result_t r;
		int unsigned  n;
		int unsigned  wl;
		int           i;
		r = '0;
		n = 0;
		case (act)
		ACT_APPEND: begin
			if (left_len + right_len < CAPACITY) begin
				text_mem[left_len] = ch;
				left_len++;
				n = 1;
			end
		end
		ACT_DELETE: begin
			n = (req < left_len) ? req : left_len;
			left_len -= n;
		end
		ACT_LEFT: begin
			n = (req < left_len) ? req : left_len;
			repeat (n) begin
				text_mem[CAPACITY - right_len - 1] = text_mem[left_len - 1];
				left_len--;
				right_len++;
			end
		end
		default: begin
			n = (req < right_len) ? req : right_len;
			repeat (n) begin
				text_mem[left_len] = text_mem[CAPACITY - right_len];
				left_len++;
				right_len--;
			end
		end
		endcase
		wl = (left_len < WINDOW) ? left_len : WINDOW;
		for (i = 0; i < WINDOW; i++) begin
			if (i < wl)
				r.win[i] = text_mem[left_len - wl + i];
		end
		r.done = CNT_W'(n);
		r.wlen = WIN_W'(wl);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		edit_result_t got;
		edit_result_t want;
		if (!arst_n) begin
			result_q.delete();
			left_len = 0;
			right_len = 0;
			fail_total = 0;
			fail_count <= 0;
			pending_count <= 0;
		end else begin
			if (valid) begin
				got.done = count_done;
				got.wlen = window_length;
				got.win = window;
				if (result_q.size() == 0) begin
					fail_total++;
					if (fail_total <= 10)
						$display("unexpected result: count_done %0d window_length %0d window %h",
							got.done, got.wlen, got.win);
				end else begin
					want = result_q.pop_front();
					if (got !== want) begin
						fail_total++;
						if (fail_total <= 10)
							$display({"mismatch: count_done exp %0d got %0d, window_length exp %0d ",
								"got %0d, window exp %h got %h"}, want.done, got.done,
								want.wlen, got.wlen, want.win, got.win);
					end
				end
			end
			if (start && !busy)
				result_q = {result_q, apply_edit(action_t'(action), char_in, count)};
			fail_count <= fail_total;
			pending_count <= result_q.size();
		end
	end

endmodule

@@ bench/tb_gap_buffer_text_editor.sv @@
`timescale 1ns / 1ps
// top of the gap buffer text editor bench: drives edit items with random gaps
// into the block; depends on gbte_pkg, the block and its checker
module tb_gap_buffer_text_editor;
	import gbte_pkg::*;

	localparam int CYCLE_LIMIT = 4_000_000;

	logic                          clk;
	logic                          arst_n;
	logic                          start;
	logic                          busy;
	logic [1:0]                    action;
	logic [CHAR_W-1:0]             char_in;
	logic [CNT_W-1:0]              count;
	logic                          valid;
	logic [CNT_W-1:0]              count_done;
	logic [WIN_W-1:0]              window_length;
	logic [CHAR_W-1:0]             window_0;
	logic [CHAR_W-1:0]             window_1;
	logic [CHAR_W-1:0]             window_2;
	logic [CHAR_W-1:0]             window_3;
	logic [CHAR_W-1:0]             window_4;
	logic [CHAR_W-1:0]             window_5;
	logic [CHAR_W-1:0]             window_6;
	logic [CHAR_W-1:0]             window_7;
	logic [CHAR_W-1:0]             window_8;
	logic [CHAR_W-1:0]             window_9;
	wire  [WINDOW-1:0][CHAR_W-1:0] window_bus;
	int                            fail_count;
	int                            pending_count;
	int                            cycle_count = 0;
	int                            items_sent = 0;
	bit                            idle_on = 1'b1;

	assign window_bus = {window_9, window_8, window_7, window_6, window_5,
		window_4, window_3, window_2, window_1, window_0};

	gap_buffer_text_editor dut (.*);

	gap_buffer_text_editor_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.action(action),
		.char_in(char_in),
		.count(count),
		.valid(valid),
		.count_done(count_done),
		.window_length(window_length),
		.window(window_bus),
		.fail_count(fail_count),
		.pending_count(pending_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// holds the item until taken; start stays high when the next item follows at once
	task automatic send_edit(action_t act, logic [CHAR_W-1:0] ch, int cnt);
		int gap;
		gap = idle_on ? $urandom_range(0, 11) : 0;
		if ($urandom_range(0, 39) == 0)
			idle_on = !idle_on;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		action <= act;
		char_in <= ch;
		count <= CNT_W'(cnt);
		do @(posedge clk); while (busy);
		items_sent++;
	endtask

	function automatic int draw_count();
		case ($urandom_range(0, 9))
		0, 1, 2, 3, 4, 5: return $urandom_range(0, 12);
		6, 7:             return $urandom_range(0, 80);
		8:                return $urandom_range(0, 1024);
		default:          return 1024;
		endcase
	endfunction

	task automatic type_word();
		int n;
		n = $urandom_range(1, 8);
		repeat (n) begin
			if ($urandom_range(0, 3) == 0)
				send_edit(ACT_APPEND, CHAR_W'($urandom_range(0, 255)), $urandom_range(0, 1024));
			else
				send_edit(ACT_APPEND, CHAR_W'($urandom_range(8'h61, 8'h7a)), 0);
		end
	endtask

	initial begin
		int i;
		arst_n = 1'b0;
		start <= 1'b0;
		action <= ACT_APPEND;
		char_in <= '0;
		count <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty text, then a short line
		send_edit(ACT_DELETE, 8'h00, 5);
		send_edit(ACT_LEFT, 8'h00, 3);
		send_edit(ACT_RIGHT, 8'hff, 1024);
		send_edit(ACT_APPEND, 8'h00, 0);
		send_edit(ACT_APPEND, 8'hff, 1024);
		send_edit(ACT_APPEND, 8'h55, 0);
		send_edit(ACT_APPEND, 8'haa, 0);
		for (i = 0; i < 8; i++)
			send_edit(ACT_APPEND, CHAR_W'(8'h61 + i), 0);
		send_edit(ACT_DELETE, 8'h00, 0);
		send_edit(ACT_LEFT, 8'h00, 0);
		send_edit(ACT_RIGHT, 8'h00, 0);
		send_edit(ACT_LEFT, 8'h00, 4);
		send_edit(ACT_APPEND, 8'h5a, 0);
		send_edit(ACT_RIGHT, 8'h00, 2);
		send_edit(ACT_RIGHT, 8'h00, 1024);
		send_edit(ACT_LEFT, 8'h00, 1024);
		send_edit(ACT_RIGHT, 8'h00, 5);
		send_edit(ACT_DELETE, 8'h00, 1024);
		send_edit(ACT_RIGHT, 8'h00, 1024);

		// typing bursts mixed with cursor moves and deletes
		while (items_sent < 470) begin
			case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: type_word();
			5, 6:          send_edit(action_t'($urandom_range(2, 3)),
				CHAR_W'($urandom_range(0, 255)), draw_count());
			7:             send_edit(ACT_DELETE, CHAR_W'($urandom_range(0, 255)), draw_count());
			8:             send_edit(ACT_APPEND, CHAR_W'($urandom_range(0, 255)), 0);
			default:       send_edit(action_t'($urandom_range(0, 3)),
				CHAR_W'($urandom_range(0, 255)), $urandom_range(0, 1024));
			endcase
		end

		// long moves across whatever text is left, then clear it
		send_edit(ACT_RIGHT, 8'h00, 1024);
		send_edit(ACT_APPEND, 8'h41, 0);
		send_edit(ACT_LEFT, 8'h00, 1024);
		send_edit(ACT_APPEND, 8'h42, 0);
		send_edit(ACT_RIGHT, 8'h00, 1024);
		send_edit(ACT_LEFT, 8'h00, 17);
		send_edit(ACT_DELETE, 8'h00, 3);
		send_edit(ACT_APPEND, 8'h43, 0);
		send_edit(ACT_RIGHT, 8'h00, 1024);
		send_edit(ACT_DELETE, 8'h00, 1024);
		send_edit(ACT_RIGHT, 8'h00, 1024);
		send_edit(ACT_DELETE, 8'h00, 1024);
		start <= 1'b0;

		do @(posedge clk); while (pending_count != 0);
		repeat (64) @(posedge clk);
		if (fail_count == 0 && pending_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+design
design/gbte_pkg.sv
design/gbte_ram.sv
design/gap_buffer_text_editor.sv
bench/gap_buffer_text_editor_checker.sv
bench/tb_gap_buffer_text_editor.sv
